>>> hdl/cme_pkg.sv
package cme_pkg;

  localparam int Q16_W       = 17;
  localparam int FRAC_SHIFT  = 16;

  localparam logic OP_SAMPLE = 1'b0;
  localparam logic OP_REPORT = 1'b1;

  localparam logic [1:0] ROW_CLASS    = 2'd0;
  localparam logic [1:0] ROW_MACRO    = 2'd1;
  localparam logic [1:0] ROW_WEIGHTED = 2'd2;

  typedef struct packed {
    logic       op;
    logic [3:0] predicted_class;
    logic [3:0] actual_class;
  } cme_in_t;

  typedef struct packed {
    logic [1:0]       row_kind;
    logic [3:0]       class_index;
    logic [Q16_W-1:0] precision_value;
    logic [Q16_W-1:0] recall_value;
    logic [Q16_W-1:0] f1_value;
    logic [31:0]      support_value;
    logic             last_row;
  } cme_out_t;

endpackage

>>> hdl/cme_cnt_mem.sv
module cme_cnt_mem #(
  parameter int DEPTH = 16,
  parameter int WIDTH = 32,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             clr,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [DEPTH-1:0] vld_r;
  logic [WIDTH-1:0] rd_data_r;

  // entries without a valid bit read as zero
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (clr) begin
      vld_r <= '0;
    end else if (wr_en) begin
      vld_r[wr_addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= vld_r[rd_addr] ? mem[rd_addr] : '0;
  end

  assign rd_data = rd_data_r;

endmodule

>>> hdl/cme_div.sv
module cme_div #(
  parameter int NUM_W = 64
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    go,
  input  logic [NUM_W-1:0]        num,
  input  logic [NUM_W-1:0]        den,
  output logic                    done,
  output logic [cme_pkg::Q16_W-1:0] quo
);
  import cme_pkg::*;

  localparam logic [4:0] CNT_LAST = 5'(Q16_W - 1);

  logic [NUM_W-1:0] rem_r;
  logic [NUM_W-1:0] dsh_r;
  logic [Q16_W-1:0] q_r;
  logic [4:0]       cnt_r;
  logic             run_r;
  logic             done_r;
  logic             zero_r;

  // restoring division, one quotient bit per cycle, MSB first
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (go) begin
        rem_r  <= num;
        dsh_r  <= den << FRAC_SHIFT;
        q_r    <= '0;
        cnt_r  <= '0;
        zero_r <= (den == '0);
        run_r  <= 1'b1;
      end else if (run_r) begin
        if (rem_r >= dsh_r) begin
          rem_r <= rem_r - dsh_r;
          q_r   <= {q_r[Q16_W-2:0], 1'b1};
        end else begin
          q_r   <= {q_r[Q16_W-2:0], 1'b0};
        end
        dsh_r <= dsh_r >> 1;
        cnt_r <= cnt_r + 5'd1;
        if (cnt_r == CNT_LAST) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done = done_r;
  assign quo  = zero_r ? '0 : q_r;

endmodule

>>> hdl/classification_metrics_engine.sv
// Channel   Direction  Handshake                 Payload
// in_       input      start & !busy accepts     in_req  (op, predicted, actual class)
// out_      output     out_valid, one cycle      out_row (one report row)
//
// A sample request reads the three count memories, then writes back.
// A report request walks every class: a class without support is skipped; for a
// class with support the shared divider gives precision, recall and F1, then a
// shift-add accumulates the support-weighted sums. The divider then gives the
// macro and weighted averages, or two zero rows follow when no class has support.
// All divisions go through the single iterative divider.
// Reset is synchronous and active low; counts read as zero after reset.
// The receiver cannot stall; each row is shown for exactly one cycle.
module classification_metrics_engine #(
  parameter int CLASS_COUNT = 16,
  parameter int COUNT_BITS  = 32
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  cme_pkg::cme_in_t  in_req,
  output logic              out_valid,
  output cme_pkg::cme_out_t out_row
);
  import cme_pkg::*;

  localparam int IDX_W = $clog2(CLASS_COUNT);
  localparam int XW    = IDX_W + 4;
  // total support over all classes fits here
  localparam int TOT_W = COUNT_BITS + IDX_W;
  // widest dividend: weighted sum, up to 2^16 * total
  localparam int NUM_W = TOT_W + Q16_W;
  localparam int SUM_W = Q16_W + IDX_W;
  localparam logic [IDX_W-1:0] LAST_CLS = IDX_W'(CLASS_COUNT - 1);

  typedef enum logic [3:0] {
    S_IDLE, S_SMP_WR, S_RP_RD, S_RP_CHK, S_CL_GO, S_CL_WAIT, S_CL_EMIT,
    S_CL_MAC, S_AV_START, S_AV_ZERO, S_AV_GO, S_AV_WAIT, S_AV_EMIT
  } state_t;

  state_t state_r;
  logic   wph_r;

  // --- count memories -------------------------------------------------
  logic [XW-1:0]         ac_x, pc_x, cls_x;
  logic                  ac_ok, pc_ok;
  logic [IDX_W-1:0]      rd_a_addr, rd_p_addr;
  logic [COUNT_BITS-1:0] tp_rd, sup_rd, pr_rd;
  logic                  mem_clr;

  logic [IDX_W-1:0]      smp_ac_r, smp_pc_r;
  logic                  smp_pc_ok_r;
  logic                  smp_wr;

  assign ac_x  = XW'(in_req.actual_class);
  assign pc_x  = XW'(in_req.predicted_class);
  assign ac_ok = ac_x < XW'(CLASS_COUNT);
  assign pc_ok = pc_x < XW'(CLASS_COUNT);

  logic [IDX_W-1:0] cls_r;
  assign cls_x = XW'(cls_r);

  // read at the request edge in idle, else at the class being reported
  assign rd_a_addr = (state_r == S_IDLE) ? ac_x[IDX_W-1:0] : cls_r;
  assign rd_p_addr = (state_r == S_IDLE) ? pc_x[IDX_W-1:0] : cls_r;
  assign smp_wr    = (state_r == S_SMP_WR);
  assign mem_clr   = (state_r == S_AV_ZERO) || (state_r == S_AV_EMIT && wph_r);

  function automatic logic [COUNT_BITS-1:0] sat_inc(input logic [COUNT_BITS-1:0] v);
    return (v == '1) ? v : v + COUNT_BITS'(1);
  endfunction

  function automatic logic [31:0] sat32(input logic [TOT_W-1:0] v);
    logic [TOT_W+31:0] ext;
    ext = (TOT_W + 32)'(v);
    return (ext > (TOT_W + 32)'(32'hFFFF_FFFF)) ? 32'hFFFF_FFFF : ext[31:0];
  endfunction

  cme_cnt_mem #(.DEPTH(CLASS_COUNT), .WIDTH(COUNT_BITS)) u_tp_mem (
    .clk, .rst_n, .clr(mem_clr),
    .wr_en(smp_wr && smp_pc_ok_r && (smp_pc_r == smp_ac_r)),
    .wr_addr(smp_ac_r), .wr_data(sat_inc(tp_rd)),
    .rd_addr(rd_a_addr), .rd_data(tp_rd)
  );

  cme_cnt_mem #(.DEPTH(CLASS_COUNT), .WIDTH(COUNT_BITS)) u_sup_mem (
    .clk, .rst_n, .clr(mem_clr),
    .wr_en(smp_wr), .wr_addr(smp_ac_r), .wr_data(sat_inc(sup_rd)),
    .rd_addr(rd_a_addr), .rd_data(sup_rd)
  );

  cme_cnt_mem #(.DEPTH(CLASS_COUNT), .WIDTH(COUNT_BITS)) u_pr_mem (
    .clk, .rst_n, .clr(mem_clr),
    .wr_en(smp_wr && smp_pc_ok_r), .wr_addr(smp_pc_r), .wr_data(sat_inc(pr_rd)),
    .rd_addr(rd_p_addr), .rd_data(pr_rd)
  );

  // --- shared divider -------------------------------------------------
  logic [1:0]       m_r;
  logic [IDX_W:0]   n_r;
  logic [SUM_W-1:0] sum_r  [3];
  logic [NUM_W-1:0] wacc_r [3];
  logic [TOT_W-1:0] total_r;
  logic [Q16_W-1:0] met_r  [3];
  logic [Q16_W-1:0] mq_r;
  logic [NUM_W-1:0] msh_r;
  logic [4:0]       step_r;

  logic             div_go, div_done;
  logic [NUM_W-1:0] div_num, div_den;
  logic [Q16_W-1:0] div_quo;

  assign div_go = (state_r == S_CL_GO) || (state_r == S_AV_GO);

  // pick dividend and divisor for the metric in hand
  always_comb begin
    div_num = '0;
    div_den = '0;
    if (state_r == S_CL_GO) begin
      case (m_r)
        2'd0: begin
          div_num = NUM_W'(tp_rd) << FRAC_SHIFT;
          div_den = NUM_W'(pr_rd);
        end
        2'd1: begin
          div_num = NUM_W'(tp_rd) << FRAC_SHIFT;
          div_den = NUM_W'(sup_rd);
        end
        default: begin
          // F1 = 2TP / (predicted + support)
          div_num = NUM_W'(tp_rd) << (FRAC_SHIFT + 1);
          div_den = NUM_W'(pr_rd) + NUM_W'(sup_rd);
        end
      endcase
    end else if (wph_r) begin
      div_num = wacc_r[m_r];
      div_den = NUM_W'(total_r);
    end else begin
      div_num = NUM_W'(sum_r[m_r]);
      div_den = NUM_W'(n_r);
    end
  end

  cme_div #(.NUM_W(NUM_W)) u_div (
    .clk, .rst_n, .go(div_go), .num(div_num), .den(div_den),
    .done(div_done), .quo(div_quo)
  );

  // --- sequencer ------------------------------------------------------
  logic     out_valid_r;
  cme_out_t out_row_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          if (start) begin
            if (in_req.op == OP_REPORT) begin
              cls_r   <= '0;
              n_r     <= '0;
              total_r <= '0;
              for (int i = 0; i < 3; i++) begin
                sum_r[i]  <= '0;
                wacc_r[i] <= '0;
              end
              state_r <= S_RP_RD;
            end else if (ac_ok) begin
              // drop samples whose true class is out of range
              smp_ac_r    <= ac_x[IDX_W-1:0];
              smp_pc_r    <= pc_x[IDX_W-1:0];
              smp_pc_ok_r <= pc_ok;
              state_r     <= S_SMP_WR;
            end
          end
        end
        S_SMP_WR: state_r <= S_IDLE;
        S_RP_RD:  state_r <= S_RP_CHK;
        S_RP_CHK: begin
          if (sup_rd == '0) begin
            // skip classes without support
            if (cls_r == LAST_CLS) begin
              state_r <= S_AV_START;
            end else begin
              cls_r   <= cls_r + IDX_W'(1);
              state_r <= S_RP_RD;
            end
          end else begin
            m_r     <= '0;
            state_r <= S_CL_GO;
          end
        end
        S_CL_GO: state_r <= S_CL_WAIT;
        S_CL_WAIT: begin
          if (div_done) begin
            met_r[m_r] <= div_quo;
            if (m_r == 2'd2) begin
              state_r <= S_CL_EMIT;
            end else begin
              m_r     <= m_r + 2'd1;
              state_r <= S_CL_GO;
            end
          end
        end
        S_CL_EMIT: begin
          out_valid_r                 <= 1'b1;
          out_row_r.row_kind          <= ROW_CLASS;
          out_row_r.class_index       <= cls_x[3:0];
          out_row_r.precision_value   <= met_r[0];
          out_row_r.recall_value      <= met_r[1];
          out_row_r.f1_value          <= met_r[2];
          out_row_r.support_value     <= sat32(TOT_W'(sup_rd));
          out_row_r.last_row          <= 1'b0;
          n_r     <= n_r + (IDX_W + 1)'(1);
          total_r <= total_r + TOT_W'(sup_rd);
          for (int i = 0; i < 3; i++) begin
            sum_r[i] <= sum_r[i] + SUM_W'(met_r[i]);
          end
          // set up shift-add of metric * support
          m_r     <= '0;
          mq_r    <= met_r[0];
          msh_r   <= NUM_W'(sup_rd);
          step_r  <= '0;
          state_r <= S_CL_MAC;
        end
        S_CL_MAC: begin
          if (mq_r[0]) begin
            wacc_r[m_r] <= wacc_r[m_r] + msh_r;
          end
          mq_r   <= mq_r >> 1;
          msh_r  <= msh_r << 1;
          step_r <= step_r + 5'd1;
          if (step_r == 5'(Q16_W - 1)) begin
            step_r <= '0;
            if (m_r == 2'd2) begin
              if (cls_r == LAST_CLS) begin
                state_r <= S_AV_START;
              end else begin
                cls_r   <= cls_r + IDX_W'(1);
                state_r <= S_RP_RD;
              end
            end else begin
              m_r   <= m_r + 2'd1;
              mq_r  <= met_r[2'(m_r + 2'd1)];
              msh_r <= NUM_W'(sup_rd);
            end
          end
        end
        S_AV_START: begin
          out_row_r.row_kind        <= ROW_MACRO;
          out_row_r.class_index     <= '0;
          out_row_r.precision_value <= '0;
          out_row_r.recall_value    <= '0;
          out_row_r.f1_value        <= '0;
          out_row_r.support_value   <= '0;
          out_row_r.last_row        <= 1'b0;
          if (n_r == '0) begin
            // no support at all: emit two zero rows
            out_valid_r <= 1'b1;
            state_r     <= S_AV_ZERO;
          end else begin
            m_r     <= '0;
            wph_r   <= 1'b0;
            state_r <= S_AV_GO;
          end
        end
        S_AV_ZERO: begin
          out_valid_r        <= 1'b1;
          out_row_r.row_kind <= ROW_WEIGHTED;
          out_row_r.last_row <= 1'b1;
          state_r            <= S_IDLE;
        end
        S_AV_GO: state_r <= S_AV_WAIT;
        S_AV_WAIT: begin
          if (div_done) begin
            met_r[m_r] <= div_quo;
            if (m_r == 2'd2) begin
              state_r <= S_AV_EMIT;
            end else begin
              m_r     <= m_r + 2'd1;
              state_r <= S_AV_GO;
            end
          end
        end
        S_AV_EMIT: begin
          out_valid_r               <= 1'b1;
          out_row_r.row_kind        <= wph_r ? ROW_WEIGHTED : ROW_MACRO;
          out_row_r.class_index     <= '0;
          out_row_r.precision_value <= met_r[0];
          out_row_r.recall_value    <= met_r[1];
          out_row_r.f1_value        <= met_r[2];
          out_row_r.support_value   <= sat32(total_r);
          out_row_r.last_row        <= wph_r;
          if (wph_r) begin
            state_r <= S_IDLE;
          end else begin
            wph_r   <= 1'b1;
            m_r     <= '0;
            state_r <= S_AV_GO;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign busy      = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_row   = out_row_r;

  // --- checks ---------------------------------------------------------
  a_report_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_req.op == OP_REPORT) |=> busy)
    else $error("report request did not occupy the engine");

  a_last_weighted: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_row.last_row) |-> (out_row.row_kind == ROW_WEIGHTED))
    else $error("final row is not the weighted average");

  a_row_in_report: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(busy))
    else $error("row emitted outside a report");

  a_metric_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_row.precision_value <= 17'd65536 &&
                   out_row.recall_value <= 17'd65536 &&
                   out_row.f1_value <= 17'd65536))
    else $error("metric above one");

endmodule

>>> sim/classification_metrics_engine_test.sv
module classification_metrics_engine_test;
  import cme_pkg::*;

  localparam int CLASSES     = 16;
  localparam logic [31:0] COUNT_TOP = 32'hFFFF_FFFF;
  localparam int RANDOM_REQS = 257;
  localparam int CYCLE_LIMIT = 2_000_000;
  localparam int DRAIN_CYCLES = 400;
  localparam int DIRECTED_ROWS = 22;

  logic     clk;
  logic     rst_n;
  logic     start;
  logic     busy;
  cme_in_t  in_req;
  logic     out_valid;
  cme_out_t out_row;

  // Shadow copies of the per-class counters kept by the block.
  logic [31:0] hit_tally[CLASSES];
  logic [31:0] truth_tally[CLASSES];
  logic [31:0] guess_tally[CLASSES];

  cme_out_t expected_rows[$];
  int       mismatch_count;
  int       rows_seen;
  int       reports_sent;
  int       samples_sent;
  int       cycle_count;
  bit       calm_phase;

  classification_metrics_engine dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_req   (in_req),
    .out_valid(out_valid),
    .out_row  (out_row)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Hard stop in case the block hangs.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d rows outstanding", cycle_count,
               expected_rows.size());
      $display("end of test: mismatches");
      $finish;
    end
  end

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    mismatch_count++;
    $display("MISMATCH row %0d %s: got %0d want %0d", rows_seen, what, got, want);
  endtask

  // Truncated Q1.16 ratio, clamped to one when num >= den.
  function automatic logic [16:0] q16_ratio(input logic [63:0] num, input logic [63:0] den);
    if (den == 0) return 17'd0;
    if (num >= den) return 17'h10000;
    return 17'((num << 16) / den);
  endfunction

  // Weighted sums fit easily: 65536 * 16 * (2^32-1) < 2^53.
  function automatic logic [16:0] q16_weighted(input logic [63:0] sum, input logic [63:0] den);
    logic [63:0] q;
    q = sum / den;
    return (q > 64'h10000) ? 17'h10000 : 17'(q);
  endfunction

  // Advance the shadow counters for a sample, or queue every report row and clear.
  task automatic predict_metrics(input cme_in_t req);
    logic [16:0] p, r, f;
    logic [63:0] sum_p, sum_r, sum_f, wsum_p, wsum_r, wsum_f, total;
    int          reported;
    cme_out_t    row;
    sum_p = 0; sum_r = 0; sum_f = 0; wsum_p = 0; wsum_r = 0; wsum_f = 0;
    total = 0; reported = 0;
    if (req.op == OP_SAMPLE) begin
      // Both indexes are always in range at 16 classes.
      if (truth_tally[req.actual_class] != COUNT_TOP)
        truth_tally[req.actual_class]++;
      if (guess_tally[req.predicted_class] != COUNT_TOP)
        guess_tally[req.predicted_class]++;
      if (req.predicted_class == req.actual_class &&
          hit_tally[req.actual_class] != COUNT_TOP)
        hit_tally[req.actual_class]++;
      return;
    end
    for (int c = 0; c < CLASSES; c++) begin
      if (truth_tally[c] == 0) continue;
      p = q16_ratio(hit_tally[c], guess_tally[c]);
      r = q16_ratio(hit_tally[c], truth_tally[c]);
      f = q16_ratio(64'(hit_tally[c]) * 2, 64'(guess_tally[c]) + 64'(truth_tally[c]));
      row = '{ROW_CLASS, 4'(c), p, r, f, truth_tally[c], 1'b0};
      expected_rows.push_back(row);
      reported++;
      sum_p += p; sum_r += r; sum_f += f;
      total += truth_tally[c];
      wsum_p += 64'(p) * truth_tally[c];
      wsum_r += 64'(r) * truth_tally[c];
      wsum_f += 64'(f) * truth_tally[c];
    end
    if (reported > 0) begin
      row = '{ROW_MACRO, 4'd0, 17'(sum_p / reported), 17'(sum_r / reported),
              17'(sum_f / reported), (total > COUNT_TOP) ? COUNT_TOP : 32'(total), 1'b0};
      expected_rows.push_back(row);
      row = '{ROW_WEIGHTED, 4'd0, q16_weighted(wsum_p, total), q16_weighted(wsum_r, total),
              q16_weighted(wsum_f, total), (total > COUNT_TOP) ? COUNT_TOP : 32'(total),
              1'b1};
      expected_rows.push_back(row);
    end else begin
      expected_rows.push_back('{ROW_MACRO, 4'd0, 17'd0, 17'd0, 17'd0, 32'd0, 1'b0});
      expected_rows.push_back('{ROW_WEIGHTED, 4'd0, 17'd0, 17'd0, 17'd0, 32'd0, 1'b1});
    end
    for (int c = 0; c < CLASSES; c++) begin
      hit_tally[c] = 0; truth_tally[c] = 0; guess_tally[c] = 0;
    end
  endtask

  // Check every row against the oldest expected one.
  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (expected_rows.size() == 0) begin
        mismatch_count++;
        $display("MISMATCH unexpected row kind %0d class %0d", out_row.row_kind,
                 out_row.class_index);
      end else begin
        cme_out_t want;
        want = expected_rows.pop_front();
        if (out_row.row_kind != want.row_kind)
          report_mismatch("row_kind", out_row.row_kind, want.row_kind);
        if (out_row.class_index != want.class_index)
          report_mismatch("class_index", out_row.class_index, want.class_index);
        if (out_row.precision_value != want.precision_value)
          report_mismatch("precision", out_row.precision_value, want.precision_value);
        if (out_row.recall_value != want.recall_value)
          report_mismatch("recall", out_row.recall_value, want.recall_value);
        if (out_row.f1_value != want.f1_value)
          report_mismatch("f1", out_row.f1_value, want.f1_value);
        if (out_row.support_value != want.support_value)
          report_mismatch("support", out_row.support_value, want.support_value);
        if (out_row.last_row != want.last_row)
          report_mismatch("last_row", out_row.last_row, want.last_row);
      end
      rows_seen++;
    end
  end

  // Hold the request on the inputs until it is taken; prediction runs at acceptance.
  // Raise start after the previous drop, at times after a random gap; a busy engine holds it off.
  task automatic send_request(input cme_in_t req);
    int gap;
    @(negedge clk);
    if (!calm_phase && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 13);
      repeat (gap) @(negedge clk);
    end
    start  <= 1'b1;
    in_req <= req;
    @(posedge clk);
    while (busy) @(posedge clk);
    predict_metrics(req);
    if (req.op == OP_REPORT) reports_sent++;
    else samples_sent++;
    @(negedge clk);
    start <= 1'b0;
  endtask

  function automatic cme_in_t sample_req(input int pc, input int ac);
    return '{OP_SAMPLE, 4'(pc), 4'(ac)};
  endfunction

  // Directed part: each row is a request plus, where obvious, the rows it must produce.
  typedef struct {
    cme_in_t  req;
    int       typed_rows;
    cme_out_t row0;
    cme_out_t row1;
    cme_out_t row2;
  } directed_entry_t;

  directed_entry_t directed_table[DIRECTED_ROWS];

  initial begin
    cme_in_t req;
    int      burst;
    start = 1'b0;
    in_req = '0;
    rst_n = 1'b0;
    mismatch_count = 0; rows_seen = 0; reports_sent = 0; samples_sent = 0;
    cycle_count = 0; calm_phase = 1'b0;
    for (int c = 0; c < CLASSES; c++) begin
      hit_tally[c] = 0; truth_tally[c] = 0; guess_tally[c] = 0;
    end

    for (int i = 0; i < DIRECTED_ROWS; i++) directed_table[i] = '{'0, 0, '0, '0, '0};
    // Report straight after reset: only the two empty average rows.
    directed_table[0] = '{'{OP_REPORT, 4'd0, 4'd0}, 2,
                          '{ROW_MACRO, 4'd0, 17'd0, 17'd0, 17'd0, 32'd0, 1'b0},
                          '{ROW_WEIGHTED, 4'd0, 17'd0, 17'd0, 17'd0, 32'd0, 1'b1}, '0};
    // One perfect hit on the top class: every metric is one.
    directed_table[1] = '{sample_req(15, 15), 0, '0, '0, '0};
    directed_table[2] = '{'{OP_REPORT, 4'd15, 4'd15}, 3,
                          '{ROW_CLASS, 4'd15, 17'h10000, 17'h10000, 17'h10000, 32'd1, 1'b0},
                          '{ROW_MACRO, 4'd0, 17'h10000, 17'h10000, 17'h10000, 32'd1, 1'b0},
                          '{ROW_WEIGHTED, 4'd0, 17'h10000, 17'h10000, 17'h10000, 32'd1,
                            1'b1}};
    // Class 0 never predicted right, predicted class with no support is not reported.
    directed_table[3] = '{sample_req(15, 0), 0, '0, '0, '0};
    directed_table[4] = '{'{OP_REPORT, 4'd0, 4'd0}, 3,
                          '{ROW_CLASS, 4'd0, 17'd0, 17'd0, 17'd0, 32'd1, 1'b0},
                          '{ROW_MACRO, 4'd0, 17'd0, 17'd0, 17'd0, 32'd1, 1'b0},
                          '{ROW_WEIGHTED, 4'd0, 17'd0, 17'd0, 17'd0, 32'd1, 1'b1}};
    // Mixed set checked by the predictor: thirds and partial hits.
    directed_table[5]  = '{sample_req(3, 3), 0, '0, '0, '0};
    directed_table[6]  = '{sample_req(3, 5), 0, '0, '0, '0};
    directed_table[7]  = '{sample_req(5, 3), 0, '0, '0, '0};
    directed_table[8]  = '{sample_req(3, 3), 0, '0, '0, '0};
    directed_table[9]  = '{sample_req(10, 5), 0, '0, '0, '0};
    directed_table[10] = '{sample_req(0, 15), 0, '0, '0, '0};
    directed_table[11] = '{sample_req(15, 0), 0, '0, '0, '0};
    directed_table[12] = '{'{OP_REPORT, 4'd5, 4'd10}, 0, '0, '0, '0};
    // Every odd class once, each a hit.
    for (int i = 0; i < 8; i++)
      directed_table[13 + i] = '{sample_req(i * 2 + 1, i * 2 + 1), 0, '0, '0, '0};
    directed_table[21] = '{'{OP_REPORT, 4'd15, 4'd0}, 0, '0, '0, '0};

    repeat (6) @(negedge clk);
    rst_n = 1'b1;

    for (int i = 0; i < DIRECTED_ROWS; i++) begin
      send_request(directed_table[i].req);
      // Overwrite the predicted rows with the typed ones where given.
      if (directed_table[i].typed_rows > 0) begin
        for (int k = 0; k < directed_table[i].typed_rows; k++)
          void'(expected_rows.pop_back());
        expected_rows.push_back(directed_table[i].row0);
        expected_rows.push_back(directed_table[i].row1);
        if (directed_table[i].typed_rows == 3) expected_rows.push_back(directed_table[i].row2);
      end
    end

    // Pause until the last report has fully drained.
    while (expected_rows.size() != 0) @(negedge clk);

    // Random part: bursts of samples with a report every so often.
    for (int i = 0; i < RANDOM_REQS; i++) begin
      if (i > RANDOM_REQS * 4 / 5) calm_phase = 1'b1;
      if ($urandom_range(0, 14) == 0) begin
        req = '{OP_REPORT, 4'($urandom), 4'($urandom)};
      end else begin
        burst = $urandom_range(0, 3);
        if (burst == 0) req = sample_req($urandom_range(0, 15), $urandom_range(0, 15));
        else if (burst == 1) begin
          // Skew toward a few classes so hits and full-scale metrics appear.
          req = sample_req($urandom_range(0, 2), $urandom_range(0, 2));
        end else begin
          req = sample_req(0, 0);
          req.actual_class = 4'($urandom_range(0, 15));
          req.predicted_class = ($urandom_range(0, 1) != 0) ? req.actual_class
                                                            : 4'($urandom);
        end
      end
      send_request(req);
    end
    send_request('{OP_REPORT, 4'd0, 4'd0});

    while (expected_rows.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);

    $display("covered %0d samples and %0d reports, %0d rows checked", samples_sent,
             reports_sent, rows_seen);
    if (mismatch_count == 0 && expected_rows.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
